[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/cst_pkg.sv]
// ----------------------------------------------------------------------------
// cst_pkg
// shared types, token kind codes and character class functions of the scanner
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int PREFIX_DEPTH_DEF = 8;
  localparam int LENGTH_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF  = 2;

  localparam int CHAR_W    = 8;
  localparam int KIND_W    = 6;
  localparam int START_W   = 32;
  localparam int OUT_LEN_W = 16;

  // longest keyword, also the prefix part carried with a finished word
  localparam int KW_MAX_LEN = 8;
  localparam int KW_LEN_W   = 4;
  localparam int NUM_KW     = 10;

  // token kinds
  localparam logic [KIND_W-1:0] K_IDENT    = 6'd0;
  localparam logic [KIND_W-1:0] K_INT      = 6'd1;
  localparam logic [KIND_W-1:0] K_FLOAT    = 6'd2;
  localparam logic [KIND_W-1:0] K_KW_FIRST = 6'd3;
  localparam logic [KIND_W-1:0] K_KW_LAST  = 6'd12;
  localparam logic [KIND_W-1:0] K_PLUS     = 6'd13;
  localparam logic [KIND_W-1:0] K_MINUS    = 6'd14;
  localparam logic [KIND_W-1:0] K_STAR     = 6'd15;
  localparam logic [KIND_W-1:0] K_SLASH    = 6'd16;
  localparam logic [KIND_W-1:0] K_PERCENT  = 6'd17;
  localparam logic [KIND_W-1:0] K_LT       = 6'd18;
  localparam logic [KIND_W-1:0] K_GT       = 6'd19;
  localparam logic [KIND_W-1:0] K_COLON    = 6'd20;
  localparam logic [KIND_W-1:0] K_ASSIGN   = 6'd21;
  localparam logic [KIND_W-1:0] K_SEMI     = 6'd22;
  localparam logic [KIND_W-1:0] K_COMMA    = 6'd23;
  localparam logic [KIND_W-1:0] K_LPAREN   = 6'd24;
  localparam logic [KIND_W-1:0] K_RPAREN   = 6'd25;
  localparam logic [KIND_W-1:0] K_LBRACK   = 6'd26;
  localparam logic [KIND_W-1:0] K_RBRACK   = 6'd27;
  localparam logic [KIND_W-1:0] K_LBRACE   = 6'd28;
  localparam logic [KIND_W-1:0] K_RBRACE   = 6'd29;
  localparam logic [KIND_W-1:0] K_NOT      = 6'd30;
  localparam logic [KIND_W-1:0] K_LE       = 6'd31;
  localparam logic [KIND_W-1:0] K_GE       = 6'd32;
  localparam logic [KIND_W-1:0] K_EQ       = 6'd33;
  localparam logic [KIND_W-1:0] K_NE       = 6'd34;
  localparam logic [KIND_W-1:0] K_ANDAND   = 6'd35;
  localparam logic [KIND_W-1:0] K_OROR     = 6'd36;

  // keyword text, right justified, first character highest
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KW] = '{
    "const", "void", "int", "float", "if",
    "else", "while", "continue", "break", "return"
  };
  localparam logic [KW_LEN_W-1:0] KW_LEN [NUM_KW] = '{
    4'd5, 4'd4, 4'd3, 4'd5, 4'd2, 4'd4, 4'd5, 4'd8, 4'd5, 4'd6
  };

  // finished word handed from the front to the back
  typedef struct packed {
    logic                              is_ident;
    logic [KIND_W-1:0]                 kind;
    logic                              kw_fit;
    logic [KW_LEN_W-1:0]               kw_len;
    logic [KW_MAX_LEN-1:0][CHAR_W-1:0] prefix;
    logic [START_W-1:0]                start;
    logic [OUT_LEN_W-1:0]              len;
  } cst_rec_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic is_hexish(input logic [CHAR_W-1:0] c);
    return ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F")) ||
           (c == "x") || (c == "X");
  endfunction

  // ident code for anything that is not a single operator
  function automatic logic [KIND_W-1:0] single_kind(input logic [CHAR_W-1:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      "%":     k = K_PERCENT;
      "<":     k = K_LT;
      ">":     k = K_GT;
      ":":     k = K_COLON;
      "=":     k = K_ASSIGN;
      ";":     k = K_SEMI;
      ",":     k = K_COMMA;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "[":     k = K_LBRACK;
      "]":     k = K_RBRACK;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "!":     k = K_NOT;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

  function automatic logic is_op(input logic [CHAR_W-1:0] c);
    return (single_kind(c) != K_IDENT) || (c == "&") || (c == "|");
  endfunction

  function automatic logic [KIND_W-1:0] pair_kind(input logic [CHAR_W-1:0] first,
                                                  input logic [CHAR_W-1:0] second);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    if (second == "=") begin
      unique case (first)
        "<":     k = K_LE;
        ">":     k = K_GE;
        "=":     k = K_EQ;
        "!":     k = K_NE;
        default: k = K_IDENT;
      endcase
    end else if ((second == "&") && (first == "&")) begin
      k = K_ANDAND;
    end else if ((second == "|") && (first == "|")) begin
      k = K_OROR;
    end
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] kw_kind(
      input logic [KW_MAX_LEN-1:0][CHAR_W-1:0] pre,
      input logic [KW_LEN_W-1:0]               len,
      input logic                              fit);
    logic [KIND_W-1:0] k_out;
    logic              same;
    k_out = K_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      same = fit && (len == KW_LEN[k]);
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (i < int'(KW_LEN[k])) begin
          same = same && (pre[i] == KW_TEXT[k][CHAR_W*(int'(KW_LEN[k])-1-i) +: CHAR_W]);
        end
      end
      if (same) begin
        k_out = KIND_W'(int'(K_KW_FIRST) + k);
      end
    end
    return k_out;
  endfunction

endpackage

[rtl/cst_if.sv]
// ----------------------------------------------------------------------------
// cst_if
// valid/ready channels of the scanner: source bytes in, tokens out
// ----------------------------------------------------------------------------
interface cst_in_if import cst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

interface cst_out_if import cst_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    token_kind;
  logic [START_W-1:0]   token_start;
  logic [OUT_LEN_W-1:0] token_length;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, output ready);
endinterface

[rtl/cst_front.sv]
// ----------------------------------------------------------------------------
// cst_front
// lexer state machine: takes one byte a cycle while the queue is not full,
// tracks the open token and pushes every finished token into the queue
// ----------------------------------------------------------------------------
module cst_front import cst_pkg::*; #(
  parameter int PREFIX_DEPTH = PREFIX_DEPTH_DEF,
  parameter int LENGTH_BITS  = LENGTH_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  cst_in_if.sink   in_chan,
  input  logic     q_full,
  output logic     push,
  output cst_rec_t push_rec
);

  localparam int                     IDX_W   = $clog2(PREFIX_DEPTH);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  localparam logic [2:0] MODE_EMPTY = 3'd0;
  localparam logic [2:0] MODE_IDENT = 3'd1;
  localparam logic [2:0] MODE_INT   = 3'd2;
  localparam logic [2:0] MODE_FLOAT = 3'd3;
  localparam logic [2:0] MODE_OP    = 3'd4;

  logic [2:0]             mode_r, mode_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [START_W-1:0]     start_r, start_nxt;
  logic [START_W-1:0]     pos_r, pos_nxt;
  logic [CHAR_W-1:0]      prefix_r [PREFIX_DEPTH];

  logic                   acc;
  logic [CHAR_W-1:0]      c;
  logic                   c_digit, c_alpha, c_op, c_dot;
  logic [KIND_W-1:0]      pk;
  logic                   has_room;
  logic [LENGTH_BITS-1:0] len_inc;
  logic                   do_append, do_begin;
  logic [2:0]             begin_mode;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [LENGTH_BITS-1:0] emit_len;
  logic [KIND_W-1:0]      emit_kind;
  logic                   emit_ident;
  logic [31:0]            len32;

  assign in_chan.ready = !q_full;
  assign acc           = in_chan.valid && !q_full;
  assign c             = in_chan.character;

  assign c_digit  = is_digit(c);
  assign c_alpha  = is_alpha(c);
  assign c_op     = is_op(c);
  assign c_dot    = (c == ".");
  assign pk       = pair_kind(prefix_r[0], c);
  assign has_room = 32'(len_r) < 32'(PREFIX_DEPTH);
  assign len_inc  = (len_r != LEN_MAX) ? LENGTH_BITS'(len_r + 1'b1) : len_r;

  always_comb begin
    mode_nxt   = mode_r;
    len_nxt    = len_r;
    start_nxt  = start_r;
    pos_nxt    = pos_r;
    do_append  = 1'b0;
    do_begin   = 1'b0;
    begin_mode = MODE_EMPTY;
    push       = 1'b0;
    emit_len   = len_r;
    emit_kind  = K_IDENT;
    emit_ident = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = '0;

    if (acc) begin
      pos_nxt = pos_r + 1'b1;
      unique case (mode_r)
        MODE_EMPTY: begin
          priority if (c_digit) begin
            do_begin   = 1'b1;
            begin_mode = MODE_INT;
          end else if (c_alpha) begin
            do_begin   = 1'b1;
            begin_mode = MODE_IDENT;
          end else if (c_op) begin
            do_begin   = 1'b1;
            begin_mode = MODE_OP;
          end else if (c_dot) begin
            do_begin   = 1'b1;
            begin_mode = MODE_FLOAT;
          end else begin
            do_begin = 1'b0;
          end
        end
        MODE_IDENT, MODE_INT, MODE_FLOAT: begin
          if ((mode_r == MODE_IDENT) && (c_alpha || c_digit)) begin
            do_append = 1'b1;
          end else if ((mode_r == MODE_INT) && (c_digit || c_dot || is_hexish(c))) begin
            do_append = 1'b1;
            if (c_dot) begin
              mode_nxt = MODE_FLOAT;
            end
          end else if ((mode_r == MODE_FLOAT) && c_digit) begin
            do_append = 1'b1;
          end else begin
            // token ends here, byte starts an operator or is dropped
            push       = 1'b1;
            emit_ident = (mode_r == MODE_IDENT);
            emit_kind  = (mode_r == MODE_FLOAT) ? K_FLOAT : K_INT;
            mode_nxt   = MODE_EMPTY;
            len_nxt    = '0;
            if (c_op) begin
              do_begin   = 1'b1;
              begin_mode = MODE_OP;
            end
          end
        end
        MODE_OP: begin
          push = 1'b1;
          if (pk != K_IDENT) begin
            emit_kind = pk;
            emit_len  = len_inc;
            mode_nxt  = MODE_EMPTY;
            len_nxt   = '0;
          end else begin
            // lone & or | falls out as ident
            emit_kind = single_kind(prefix_r[0]);
            mode_nxt  = MODE_EMPTY;
            len_nxt   = '0;
            priority if (c_op) begin
              do_begin   = 1'b1;
              begin_mode = MODE_OP;
            end else if (c_digit) begin
              do_begin   = 1'b1;
              begin_mode = MODE_INT;
            end else if (c_alpha) begin
              do_begin   = 1'b1;
              begin_mode = MODE_IDENT;
            end else if (c_dot) begin
              do_begin   = 1'b1;
              begin_mode = MODE_FLOAT;
            end else begin
              do_begin = 1'b0;
            end
          end
        end
        default: begin
          mode_nxt = MODE_EMPTY;
          len_nxt  = '0;
        end
      endcase

      if (do_append) begin
        wr_en   = has_room;
        wr_idx  = len_r[IDX_W-1:0];
        len_nxt = len_inc;
      end
      if (do_begin) begin
        mode_nxt  = begin_mode;
        start_nxt = pos_r;
        len_nxt   = LENGTH_BITS'(1);
        wr_en     = 1'b1;
        wr_idx    = '0;
      end
    end
  end

  assign len32 = 32'(emit_len);

  always_comb begin
    push_rec.is_ident = emit_ident;
    push_rec.kind     = emit_kind;
    push_rec.kw_fit   = len32 <= 32'(KW_MAX_LEN);
    push_rec.kw_len   = len32[KW_LEN_W-1:0];
    for (int i = 0; i < KW_MAX_LEN; i++) begin
      push_rec.prefix[i] = prefix_r[i];
    end
    push_rec.start = start_r;
    push_rec.len   = len32[OUT_LEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_EMPTY;
      len_r   <= '0;
      start_r <= '0;
      pos_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      len_r   <= len_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prefix_r[wr_idx] <= c;
    end
  end

endmodule

[rtl/cst_fifo.sv]
// ----------------------------------------------------------------------------
// cst_fifo
// short token queue between the lexer front and the output back
// ----------------------------------------------------------------------------
module cst_fifo import cst_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  cst_rec_t push_rec,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output cst_rec_t head_rec
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cst_rec_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_rec   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    priority if (do_push && !do_pop) begin
      cnt_nxt = CNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = CNT_W'(cnt_r - 1'b1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

[rtl/cst_back.sv]
// ----------------------------------------------------------------------------
// cst_back
// resolves keywords on the queue head and holds the result word in the
// output register
// ----------------------------------------------------------------------------
module cst_back import cst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  cst_rec_t  head_rec,
  output logic      pop,
  cst_out_if.source out_chan
);

  logic                 out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]    kind_r;
  logic [START_W-1:0]   start_r;
  logic [OUT_LEN_W-1:0] len_r;
  logic [KIND_W-1:0]    head_kind;

  assign pop = head_valid && (!out_valid_r || out_chan.ready);

  assign head_kind = head_rec.is_ident ?
                     kw_kind(head_rec.prefix, head_rec.kw_len, head_rec.kw_fit) :
                     head_rec.kind;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= head_kind;
      start_r <= head_rec.start;
      len_r   <= head_rec.len;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.token_kind   = kind_r;
  assign out_chan.token_start  = start_r;
  assign out_chan.token_length = len_r;

endmodule

[rtl/c_subset_token_scanner.sv]
// ----------------------------------------------------------------------------
// c_subset_token_scanner
// Takes one source byte per word and returns one token word for each byte
// that ends a token. The scanner accepts a byte every clock cycle as long as
// the token queue has room; a token word enters the queue with the byte that
// ends it, passes to the output register and waits there while the queue
// keeps taking bytes. Throughput is set by the lexer state update, one byte
// per cycle while the queue has room. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module c_subset_token_scanner import cst_pkg::*; #(
  parameter int PREFIX_DEPTH = PREFIX_DEPTH_DEF,
  parameter int LENGTH_BITS  = LENGTH_BITS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  cst_in_if.sink    in_chan,
  cst_out_if.source out_chan
);

  logic     push;
  logic     q_full;
  logic     pop;
  logic     head_valid;
  cst_rec_t push_rec;
  cst_rec_t head_rec;

  cst_front #(
    .PREFIX_DEPTH (PREFIX_DEPTH),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  cst_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec)
  );

  cst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

[rtl/cst_checker.sv]
// ----------------------------------------------------------------------------
// cst_checker
// port level checks on the token channel, bound to the scanner top
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cst_checker import cst_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  cst_out_if.source out_chan
);

  `ASSERT_NEXT(a_valid_hold, out_chan.valid && !out_chan.ready, out_chan.valid)
  `ASSERT_NEXT(a_word_hold, out_chan.valid && !out_chan.ready, $stable(out_chan.token_kind) && $stable(out_chan.token_start) && $stable(out_chan.token_length))
  `ASSERT_IMPL(a_len_nonzero, out_chan.valid, out_chan.token_length != '0)
  `ASSERT_IMPL(a_kw_len, out_chan.valid && (out_chan.token_kind >= K_KW_FIRST) && (out_chan.token_kind <= K_KW_LAST), (out_chan.token_length >= 16'd2) && (out_chan.token_length <= 16'd8))
  `ASSERT_IMPL(a_pair_len, out_chan.valid && (out_chan.token_kind >= K_LE) && (out_chan.token_kind <= K_OROR), out_chan.token_length == 16'd2)

endmodule

bind c_subset_token_scanner cst_checker u_cst_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_chan (out_chan)
);

[bench/tb_c_subset_token_scanner.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_c_subset_token_scanner
// Sends source bytes into the scanner and checks every token word that comes
// out against a lexer model kept in the bench. Keywords, literals, single and
// paired operators and dropped bytes are driven first. After that come random
// token streams mixed with noise, under changing sender and receiver idling
// and a long receiver stall, and last keyword text at the head of longer names.
// ----------------------------------------------------------------------------
module tb_c_subset_token_scanner import cst_pkg::*; ();

  typedef enum logic [2:0] {
    SCAN_EMPTY, SCAN_IDENT, SCAN_INT, SCAN_FLOAT, SCAN_OP
  } scan_mode_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [START_W-1:0]   start;
    logic [OUT_LEN_W-1:0] len;
  } token_t;

  localparam int          PREFIX_KEEP = 8;
  localparam logic [31:0] LEN_CAP     = 32'h0000_FFFF;
  localparam int          MAX_REPORTS = 10;

  localparam logic [63:0] KW_WORDS [NUM_KW] = '{
    "const", "void", "int", "float", "if",
    "else", "while", "continue", "break", "return"
  };

  localparam string ID_FIRST = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string ID_REST  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam string DIGITS   = "0123456789";
  localparam string HEX_CHARS = "0123456789abcdefABCDEFxX";
  localparam string OP_CHARS = "+-*/%<>:=;,()[]{}!&|";
  localparam string PAIRS    = "<=>===!=&&||";
  localparam string GAPS     = " \n\t.#@\"'?~$\\";

  logic clk;
  logic rst_n;

  cst_in_if  in_chan ();
  cst_out_if out_chan ();

  c_subset_token_scanner DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // lexer state of the bench
  scan_mode_t  lex_mode;
  logic [7:0]  lex_prefix [PREFIX_KEEP];
  logic [31:0] lex_len;
  logic [31:0] lex_start;
  logic [31:0] lex_pos;

  logic [7:0] pending_chars [$];
  token_t     expected_tokens [$];
  int         chars_queued;
  int         fail_count;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         rx_hold_left;
  bit         char_taken;
  token_t     new_token;
  token_t     want_token;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic logic [KIND_W-1:0] op_single(input logic [7:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "*":     k = K_STAR;
      "/":     k = K_SLASH;
      "%":     k = K_PERCENT;
      "<":     k = K_LT;
      ">":     k = K_GT;
      ":":     k = K_COLON;
      "=":     k = K_ASSIGN;
      ";":     k = K_SEMI;
      ",":     k = K_COMMA;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "[":     k = K_LBRACK;
      "]":     k = K_RBRACK;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "!":     k = K_NOT;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

  function automatic bit op_char(input logic [7:0] c);
    return (op_single(c) != K_IDENT) || (c == "&") || (c == "|");
  endfunction

  function automatic bit dec_char(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit word_char(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic bit hex_letter(input logic [7:0] c);
    return ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F")) ||
           (c == "x") || (c == "X");
  endfunction

  // K_IDENT here means the two bytes do not form a pair
  function automatic logic [KIND_W-1:0] op_pair(input logic [7:0] first,
                                                input logic [7:0] second);
    logic [KIND_W-1:0] k;
    k = K_IDENT;
    if (second == "=") begin
      unique case (first)
        "<":     k = K_LE;
        ">":     k = K_GE;
        "=":     k = K_EQ;
        "!":     k = K_NE;
        default: k = K_IDENT;
      endcase
    end else if ((second == "&") && (first == "&")) begin
      k = K_ANDAND;
    end else if ((second == "|") && (first == "|")) begin
      k = K_OROR;
    end
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] ident_or_keyword();
    logic [63:0]       w;
    logic [KIND_W-1:0] k;
    w = '0;
    k = K_IDENT;
    if (lex_len <= PREFIX_KEEP) begin
      for (int i = 0; i < PREFIX_KEEP; i++) begin
        if (i < lex_len) begin
          w = {w[55:0], lex_prefix[i]};
        end
      end
      for (int n = 0; n < NUM_KW; n++) begin
        if (w == KW_WORDS[n]) begin
          k = K_KW_FIRST + KIND_W'(n);
        end
      end
    end
    return k;
  endfunction

  function automatic logic [KIND_W-1:0] open_kind();
    logic [KIND_W-1:0] k;
    unique case (lex_mode)
      SCAN_IDENT: k = ident_or_keyword();
      SCAN_INT:   k = K_INT;
      SCAN_FLOAT: k = K_FLOAT;
      default:    k = op_single(lex_prefix[0]);
    endcase
    return k;
  endfunction

  function automatic void append_char(input logic [7:0] c);
    if (lex_len < PREFIX_KEEP) begin
      lex_prefix[lex_len] = c;
    end
    if (lex_len < LEN_CAP) begin
      lex_len = lex_len + 1;
    end
  endfunction

  function automatic void open_token(input scan_mode_t m, input logic [7:0] c,
                                     input logic [31:0] p);
    lex_mode  = m;
    lex_start = p;
    lex_len   = 0;
    append_char(c);
  endfunction

  function automatic token_t close_token(input logic [KIND_W-1:0] k);
    token_t t;
    t.kind  = k;
    t.start = lex_start;
    t.len   = lex_len[OUT_LEN_W-1:0];
    return t;
  endfunction

  // advances the lexer by one byte, returns 1 when the byte ends a token
  function automatic bit lex_step_token(input logic [7:0] c, output token_t tok);
    logic [31:0]       p;
    logic [KIND_W-1:0] pk;
    bit                ends;
    bit                got;
    p       = lex_pos;
    lex_pos = lex_pos + 1;
    ends    = 1'b0;
    got     = 1'b0;
    tok     = '0;
    unique case (lex_mode)
      SCAN_EMPTY: begin
        if (dec_char(c)) open_token(SCAN_INT, c, p);
        else if (word_char(c)) open_token(SCAN_IDENT, c, p);
        else if (op_char(c)) open_token(SCAN_OP, c, p);
        else if (c == ".") open_token(SCAN_FLOAT, c, p);
      end
      SCAN_IDENT: begin
        if (word_char(c) || dec_char(c)) append_char(c);
        else ends = 1'b1;
      end
      SCAN_INT: begin
        if (dec_char(c)) begin
          append_char(c);
        end else if (c == ".") begin
          append_char(c);
          lex_mode = SCAN_FLOAT;
        end else if (!op_char(c) && hex_letter(c)) begin
          append_char(c);
        end else begin
          ends = 1'b1;
        end
      end
      SCAN_FLOAT: begin
        if (dec_char(c)) append_char(c);
        else ends = 1'b1;
      end
      SCAN_OP: begin
        pk = op_pair(lex_prefix[0], c);
        got = 1'b1;
        if (pk != K_IDENT) begin
          append_char(c);
          tok      = close_token(pk);
          lex_mode = SCAN_EMPTY;
          lex_len  = 0;
        end else begin
          tok = close_token(open_kind());
          if (op_char(c)) open_token(SCAN_OP, c, p);
          else if (dec_char(c)) open_token(SCAN_INT, c, p);
          else if (word_char(c)) open_token(SCAN_IDENT, c, p);
          else if (c == ".") open_token(SCAN_FLOAT, c, p);
          else begin
            lex_mode = SCAN_EMPTY;
            lex_len  = 0;
          end
        end
      end
      default: begin
        lex_mode = SCAN_EMPTY;
        lex_len  = 0;
      end
    endcase
    if (ends) begin
      got = 1'b1;
      tok = close_token(open_kind());
      if (op_char(c)) open_token(SCAN_OP, c, p);
      else begin
        lex_mode = SCAN_EMPTY;
        lex_len  = 0;
      end
    end
    return got;
  endfunction

  task automatic push_char(input logic [7:0] c);
    pending_chars.insert(pending_chars.size(), c);
    chars_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i]);
    end
  endtask

  task automatic push_word(input logic [63:0] w);
    for (int i = 7; i >= 0; i--) begin
      if (w[8*i +: 8] != 8'h00) begin
        push_char(w[8*i +: 8]);
      end
    end
  endtask

  task automatic push_random_tokens(input int count);
    int sel;
    int n;
    int stop_at;
    stop_at = chars_queued + count;
    while (chars_queued < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 14) begin
        push_word(KW_WORDS[$urandom_range(NUM_KW-1)]);
        if ($urandom_range(4) == 0) push_char(ID_REST[$urandom_range(ID_REST.len()-1)]);
      end else if (sel < 34) begin
        n = $urandom_range(12, 1);
        push_char(ID_FIRST[$urandom_range(ID_FIRST.len()-1)]);
        repeat (n - 1) push_char(ID_REST[$urandom_range(ID_REST.len()-1)]);
      end else if (sel < 48) begin
        push_char(DIGITS[$urandom_range(9)]);
        if ($urandom_range(2) == 0) push_char("x");
        n = $urandom_range(5);
        repeat (n) push_char(HEX_CHARS[$urandom_range(HEX_CHARS.len()-1)]);
        if ($urandom_range(3) == 0) begin
          push_char(".");
          repeat ($urandom_range(3)) push_char(DIGITS[$urandom_range(9)]);
        end
      end else if (sel < 56) begin
        push_char(".");
        repeat ($urandom_range(4)) push_char(DIGITS[$urandom_range(9)]);
      end else if (sel < 70) begin
        push_char(OP_CHARS[$urandom_range(OP_CHARS.len()-1)]);
      end else if (sel < 78) begin
        n = 2 * $urandom_range(5);
        push_char(PAIRS[n]);
        push_char(PAIRS[n+1]);
      end else if (sel < 93) begin
        push_char(GAPS[$urandom_range(GAPS.len()-1)]);
      end else begin
        repeat ($urandom_range(3, 1)) push_char(8'($urandom_range(255)));
      end
      if ($urandom_range(99) < 45) push_char(" ");
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while ((pending_chars.size() != 0) || (expected_tokens.size() != 0));
  endtask

  // byte driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || char_taken) begin
      if ((pending_chars.size() != 0) && ($urandom_range(99) >= tx_idle_pct)) begin
        in_chan.valid     <= 1'b1;
        in_chan.character <= pending_chars[0];
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
    char_taken = 1'b0;
  end

  // token receiver
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_chan.ready <= 1'b0;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_tokens.size() == 0) begin
          if (fail_count < MAX_REPORTS) begin
            $display("unexpected token word: kind %0d start %0d len %0d",
                     out_chan.token_kind, out_chan.token_start, out_chan.token_length);
          end
          fail_count++;
        end else begin
          want_token = expected_tokens.pop_front();
          if ((out_chan.token_kind !== want_token.kind) ||
              (out_chan.token_start !== want_token.start) ||
              (out_chan.token_length !== want_token.len)) begin
            if (fail_count < MAX_REPORTS) begin
              $display("token mismatch: expected kind %0d start %0d len %0d, got kind %0d start %0d len %0d",
                       want_token.kind, want_token.start, want_token.len,
                       out_chan.token_kind, out_chan.token_start, out_chan.token_length);
            end
            fail_count++;
          end
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        if (lex_step_token(in_chan.character, new_token)) begin
          expected_tokens.insert(expected_tokens.size(), new_token);
        end
        void'(pending_chars.pop_front());
        char_taken = 1'b1;
      end
    end
  end

  initial begin
    rst_n             = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.character = 8'h00;
    out_chan.ready    = 1'b0;
    tx_idle_pct       = 30;
    rx_idle_pct       = 68;
    rx_hold_left      = 0;
    char_taken        = 1'b0;
    chars_queued      = 0;
    fail_count        = 0;
    lex_mode          = SCAN_EMPTY;
    lex_len           = 0;
    lex_start         = 0;
    lex_pos           = 0;
    foreach (lex_prefix[i]) lex_prefix[i] = 8'h00;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // pairs, lone ampersand and bar, dot after operator and after identifier
    push_text("if(x<=0x1F)a&b||c!-.5;e|f.3 ");
    push_char(8'hFF);
    push_char(8'h00);
    push_char(8'h80);
    push_random_tokens(400);
    wait_drained();

    tx_idle_pct = 68;
    rx_idle_pct = 30;
    push_random_tokens(400);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_left = 300;
    push_random_tokens(400);
    wait_drained();

    // keyword text at the head of longer names
    push_text("whilezzzzzzzz;continue continuex ");
    wait_drained();

    repeat (20) @(posedge clk);
    #1;
    if ((fail_count == 0) && (expected_tokens.size() == 0)) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
